@@ rtl/core/mlrt_pkg.sv @@
`default_nettype none
package mlrt_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PREV  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PREV2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS    = 2'd2;

    localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

    // operand selection of the multiply-reduce unit
    localparam logic [1:0] MODE_ACC = 2'd0;  // acc * base
    localparam logic [1:0] MODE_SQR = 2'd1;  // base * base
    localparam logic [1:0] MODE_FIN = 2'd2;  // acc top row * (a2, a1)

    // result source
    localparam logic [1:0] OSEL_REM  = 2'd0;
    localparam logic [1:0] OSEL_A1   = 2'd1;
    localparam logic [1:0] OSEL_ZERO = 2'd2;

    typedef struct packed {
        logic       load;
        logic       mac_start;
        logic       store;
        logic       commit;
        logic       shift;
        logic       out_load;
        logic [1:0] mode;
        logic [1:0] ent;
        logic       k;
        logic [1:0] osel;
    } t_cmd;

    typedef struct packed {
        logic n_one;
        logic n_zero;
        logic m_zero;
        logic ex_zero;
        logic ex_lsb;
        logic mac_done;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

@@ rtl/core/mlrt_datapath.sv @@
`default_nettype none
module mlrt_datapath import mlrt_pkg::*; #(
    parameter int VALUE_BITS = 31
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts,
    input  wire logic [VALUE_BITS-1:0] i_p,
    input  wire logic [VALUE_BITS-1:0] i_q,
    input  wire logic [VALUE_BITS-1:0] i_m,
    input  wire logic [VALUE_BITS-1:0] i_a1,
    input  wire logic [VALUE_BITS-1:0] i_a2,
    input  wire logic [VALUE_BITS-1:0] i_n,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic [VALUE_BITS-1:0]      o_out
);
    localparam int VB  = VALUE_BITS;
    localparam int PW  = 2 * VB;
    localparam int CW  = $clog2(PW);

    logic [VB-1:0] r_a1, r_a2, r_m, r_ex;
    logic          r_n_one, r_n_zero;
    logic [VB-1:0] r_acc  [4];
    logic [VB-1:0] r_base [4];
    logic [VB-1:0] r_tmp  [4];

    logic [PW-1:0] r_prod;
    logic [VB-1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic          r_ovalid;
    logic [VB-1:0] r_out;

    logic [VB-1:0] op_a, op_b, addend;
    logic [1:0]    ia, ib;
    logic [VB:0]   shifted, reduced;

    // operand selection: row i = ent[1], column j = ent[0]
    always_comb begin
        ia = {i_cmd.ent[1], i_cmd.k};
        ib = {i_cmd.k, i_cmd.ent[0]};
        unique case (i_cmd.mode)
            MODE_ACC: begin
                op_a = r_acc[ia];
                op_b = r_base[ib];
            end
            MODE_SQR: begin
                op_a = r_base[ia];
                op_b = r_base[ib];
            end
            MODE_FIN: begin
                op_a = r_acc[{1'b0, i_cmd.k}];
                op_b = i_cmd.k ? r_a1 : r_a2;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        addend = i_cmd.k ? r_rem : '0;
    end

    // one remainder bit per cycle
    always_comb begin
        shifted = {r_rem, r_prod[PW-1]};
        reduced = (shifted >= {1'b0, r_m}) ? shifted - {1'b0, r_m} : shifted;
    end

    // hold the operands and matrices
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a1      <= i_a1;
            r_a2      <= i_a2;
            r_m       <= i_m;
            r_ex      <= i_n - VB'(2);
            r_n_one   <= (i_n == VB'(1));
            r_n_zero  <= (i_n == '0);
            r_base[0] <= i_p;
            r_base[1] <= i_q;
            r_base[2] <= VB'(1);
            r_base[3] <= '0;
            r_acc[0]  <= VB'(1);
            r_acc[1]  <= '0;
            r_acc[2]  <= '0;
            r_acc[3]  <= VB'(1);
        end
        if (i_cmd.shift) begin
            r_ex <= r_ex >> 1;
        end
        if (i_cmd.store) begin
            r_tmp[i_cmd.ent] <= r_rem;
        end
        if (i_cmd.commit) begin
            for (int e = 0; e < 4; e++) begin
                if (i_cmd.mode == MODE_ACC) r_acc[e] <= r_tmp[e];
                else                        r_base[e] <= r_tmp[e];
            end
        end
        if (i_cmd.mac_start) begin
            r_prod <= ({{VB{1'b0}}, op_a} * {{VB{1'b0}}, op_b}) + PW'(addend);
            r_rem  <= '0;
            r_cnt  <= CW'(PW - 1);
        end else if (r_busy) begin
            r_prod <= r_prod << 1;
            r_rem  <= reduced[VB-1:0];
            r_cnt  <= r_cnt - CW'(1);
        end
        if (i_cmd.out_load) begin
            unique case (i_cmd.osel)
                OSEL_A1:   r_out <= r_a1;
                OSEL_ZERO: r_out <= '0;
                default:   r_out <= r_rem;
            endcase
        end
    end

    // control of the reduce unit and output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_done   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.mac_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
            if (i_cmd.out_load)   r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
        end
    end

    always_comb begin
        o_sts.n_one    = r_n_one;
        o_sts.n_zero   = r_n_zero;
        o_sts.m_zero   = (r_m == '0);
        o_sts.ex_zero  = (r_ex == '0);
        o_sts.ex_lsb   = r_ex[0];
        o_sts.mac_done = r_done;
        o_sts.out_free = !r_ovalid || i_out_ready;
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

@@ rtl/core/mlrt_ctrl.sv @@
`default_nettype none
module mlrt_ctrl import mlrt_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_LOOP   = 4'd2;
    localparam logic [3:0] S_START  = 4'd3;
    localparam logic [3:0] S_WAIT   = 4'd4;
    localparam logic [3:0] S_COMMIT = 4'd5;
    localparam logic [3:0] S_FSTART = 4'd6;
    localparam logic [3:0] S_FWAIT  = 4'd7;
    localparam logic [3:0] S_WRITE  = 4'd8;

    logic [3:0] r_state, n_state;
    logic [1:0] r_mode, n_mode;
    logic [1:0] r_ent, n_ent;
    logic       r_k, n_k;
    logic [1:0] r_osel, n_osel;

    // sequence the square-and-multiply rounds
    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_ent   = r_ent;
        n_k     = r_k;
        n_osel  = r_osel;
        o_cmd   = '0;
        o_cmd.mode = r_mode;
        o_cmd.ent  = r_ent;
        o_cmd.k    = r_k;
        o_cmd.osel = r_osel;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_sts.n_one) begin
                    n_osel  = OSEL_A1;
                    n_state = S_WRITE;
                end else if (i_sts.n_zero || i_sts.m_zero) begin
                    n_osel  = OSEL_ZERO;
                    n_state = S_WRITE;
                end else begin
                    n_state = S_LOOP;
                end
            end
            S_LOOP: begin
                n_ent = '0;
                n_k   = 1'b0;
                priority if (i_sts.ex_zero) begin
                    n_mode  = MODE_FIN;
                    n_state = S_FSTART;
                end else if (i_sts.ex_lsb) begin
                    n_mode  = MODE_ACC;
                    n_state = S_START;
                end else begin
                    n_mode  = MODE_SQR;
                    n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.mac_start = 1'b1;
                n_state         = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.mac_done) begin
                    if (!r_k) begin
                        n_k     = 1'b1;
                        n_state = S_START;
                    end else begin
                        o_cmd.store = 1'b1;
                        n_k         = 1'b0;
                        if (r_ent == 2'd3) begin
                            n_state = S_COMMIT;
                        end else begin
                            n_ent   = r_ent + 2'd1;
                            n_state = S_START;
                        end
                    end
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_ent        = '0;
                n_k          = 1'b0;
                if (r_mode == MODE_ACC) begin
                    n_mode  = MODE_SQR;
                    n_state = S_START;
                end else begin
                    o_cmd.shift = 1'b1;
                    n_state     = S_LOOP;
                end
            end
            S_FSTART: begin
                o_cmd.mac_start = 1'b1;
                n_state         = S_FWAIT;
            end
            S_FWAIT: begin
                if (i_sts.mac_done) begin
                    if (!r_k) begin
                        n_k     = 1'b1;
                        n_state = S_FSTART;
                    end else begin
                        n_osel  = OSEL_REM;
                        n_state = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= MODE_ACC;
            r_ent   <= '0;
            r_k     <= 1'b0;
            r_osel  <= OSEL_REM;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_ent   <= n_ent;
            r_k     <= n_k;
            r_osel  <= n_osel;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/modular_linear_recurrence_term_core.sv @@
`default_nettype none
// channel   | dir | fields (tdata, lowest bit up)
// s_axis    | in  | first_term, second_term, term_index, zero pad to bytes
// m_axis    | out | term_value, zero pad to bytes
// cfg       | in  | 0 coef_prev, 1 coef_prev2, 2 modulus
// An item runs each modular multiply-add in the shared bit-serial reduce
// unit; a matrix product is 8 of them, a round one or two products, up to
// VALUE_BITS rounds. Index one, index zero and modulus zero skip the rounds.
// Synchronous active-low reset; no clearing pass. A waiting result does not
// block the next input beat; only the held output register stalls the write.
module modular_linear_recurrence_term_core import mlrt_pkg::*; #(
    parameter int VALUE_BITS = 31
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // first_term, second_term, term_index
    input  wire logic [((3*VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // term_value
    output logic [((VALUE_BITS+7)/8)*8-1:0] m_axis_tdata,
    input  wire logic                   i_cfg_wen,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [VALUE_BITS-1:0]  i_cfg_wdata
);
    localparam int VB    = VALUE_BITS;
    localparam int OUT_W = ((VALUE_BITS + 7) / 8) * 8;

    logic [VB-1:0] r_p, r_q, r_m;
    logic [VB-1:0] out_val;
    t_cmd          cmd;
    t_sts          sts;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p <= VB'(1);
            r_q <= VB'(1);
            r_m <= MODULUS_RESET[VB-1:0];
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                REG_COEF_PREV:  r_p <= i_cfg_wdata;
                REG_COEF_PREV2: r_q <= i_cfg_wdata;
                REG_MODULUS:    r_m <= i_cfg_wdata;
                default:        ;
            endcase
        end
    end

    mlrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mlrt_datapath #(.VALUE_BITS(VB)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_p         (r_p),
        .i_q         (r_q),
        .i_m         (r_m),
        .i_a1        (s_axis_tdata[VB-1:0]),
        .i_a2        (s_axis_tdata[2*VB-1:VB]),
        .i_n         (s_axis_tdata[3*VB-1:2*VB]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out       (out_val)
    );

    assign m_axis_tdata = OUT_W'(out_val);

endmodule
`default_nettype wire
